FILE: hdl/cubic_bezier_sampler_defines.svh
// Assertion shorthands used by the RTL core (cbz_core).
// Each one expects signals named clk and rst_n in the enclosing module.
`ifndef CUBIC_BEZIER_SAMPLER_DEFINES_SVH
`define CUBIC_BEZIER_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbz_pkg.sv
`timescale 1ns / 1ps

package cbz_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int MAX_POINTS  = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int LEN_W       = 23;
  localparam int U_W         = 17;
  localparam int MUL_A_W     = 24;
  localparam int MUL_B_W     = 16;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam logic [COORD_WIDTH-1:0] CSIGN   = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
  localparam logic [LEN_W-1:0]       LEN_MAX = '1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] p0_x;
    logic [COORD_WIDTH-1:0] p0_y;
    logic [COORD_WIDTH-1:0] p1_x;
    logic [COORD_WIDTH-1:0] p1_y;
    logic [COORD_WIDTH-1:0] p2_x;
    logic [COORD_WIDTH-1:0] p2_y;
    logic [COORD_WIDTH-1:0] p3_x;
    logic [COORD_WIDTH-1:0] p3_y;
    logic [CNT_W-1:0]       num_points;
  } cbz_req_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] point_x;
    logic [COORD_WIDTH-1:0] point_y;
    logic [IDX_W-1:0]       point_index;
    logic                   last_point;
    logic [LEN_W-1:0]       curve_length;
  } cbz_res_t;

endpackage

FILE: hdl/cbz_mul.sv
`timescale 1ns / 1ps

module cbz_mul import cbz_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  logic [MUL_P_W-1:0] p_r;

  // Unsigned product, registered so the next step sees a clean operand.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    end
  end

  assign p = p_r;

endmodule

FILE: hdl/cbz_core.sv
`timescale 1ns / 1ps

module cbz_core import cbz_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cbz_req_t req,
  output logic     busy,
  output logic     emit_valid,
  input  logic     emit_ready,
  output cbz_res_t emit_res
);

  `include "cubic_bezier_sampler_defines.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PT   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_ADDL = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  // Micro-steps of the shared multiplier.
  localparam logic [4:0] STEP_UU    = 5'd0;
  localparam logic [4:0] STEP_VV    = 5'd1;
  localparam logic [4:0] STEP_UV    = 5'd2;
  localparam logic [4:0] STEP_W0H   = 5'd3;
  localparam logic [4:0] STEP_W0L   = 5'd4;
  localparam logic [4:0] STEP_W3H   = 5'd5;
  localparam logic [4:0] STEP_W3L   = 5'd6;
  localparam logic [4:0] STEP_W1H   = 5'd7;
  localparam logic [4:0] STEP_W1L   = 5'd8;
  localparam logic [4:0] STEP_W2H   = 5'd9;
  localparam logic [4:0] STEP_W2L   = 5'd10;
  localparam logic [4:0] STEP_X0    = 5'd11;
  localparam logic [4:0] STEP_X_END = 5'd18;
  localparam logic [4:0] STEP_Y0    = 5'd19;
  localparam logic [4:0] STEP_Y_END = 5'd26;
  localparam logic [4:0] STEP_SQX   = 5'd27;
  localparam logic [4:0] STEP_SQY   = 5'd28;

  localparam logic [63:0] RND      = 64'h0000_8000_0000_0000;
  localparam logic [33:0] SBIT_TOP = 34'h1_0000_0000;
  localparam logic [U_W-1:0] U_ONE = U_W'(1) << 16;

  logic [2:0]             state_r;
  logic [4:0]             step_r;
  logic                   ph_r;
  logic [COORD_WIDTH-1:0] qx_r [4];
  logic [COORD_WIDTH-1:0] qy_r [4];
  logic [IDX_W-1:0]       d_r;
  logic [IDX_W-1:0]       i_r;
  logic [U_W-1:0]         quo_r;
  logic [6:0]             drem_r;
  logic [4:0]             dcnt_r;
  logic [U_W-1:0]         u_r;
  logic [IDX_W-1:0]       rem_r;
  logic [LEN_W-1:0]       total_r;
  logic [COORD_WIDTH-1:0] x_r, y_r, px_r, py_r;
  logic [31:0]            u2_r, v2_r, uv3_r;
  logic [47:0]            w_r [4];
  logic [63:0]            acc_r;
  logic [33:0]            sq_r;
  logic [34:0]            srem_r, sres_r;
  logic [33:0]            sbit_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_en;
  logic [MUL_P_W-1:0] p;

  logic [U_W-1:0]         vfull;
  logic [15:0]            u16, v16;
  logic [4:0]             cstep;
  logic [1:0]             wk;
  logic                   whi;
  logic [47:0]            wsel;
  logic [COORD_WIDTH-1:0] qsel;
  logic [63:0]            term, acc_sum;
  logic [COORD_WIDTH-1:0] dx, dy;
  logic [33:0]            tri_uv;
  logic [6:0]             drem_sh;
  logic                   div_ge;
  logic [6:0]             drem_nx;
  logic [34:0]            s_try;
  logic                   s_ge;
  logic [6:0]             rsum;
  logic                   rcarry;
  logic [23:0]            len_sum;
  logic [CNT_W-1:0]       n_cl;
  logic                   last;
  logic                   emit_fire;

  cbz_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  always_comb begin
    vfull   = U_ONE - u_r;
    u16     = u_r[15:0];
    v16     = vfull[15:0];
    cstep   = step_r - STEP_X0;
    wk      = cstep[2:1];
    whi     = ~cstep[0];
    wsel    = w_r[wk];
    qsel    = cstep[3] ? qy_r[wk] : qx_r[wk];
    term    = whi ? {p, 24'b0} : {24'b0, p};
    acc_sum = ((cstep[2:0] == 3'd0) ? RND : acc_r) + term;
    dx      = (x_r >= px_r) ? (x_r - px_r) : (px_r - x_r);
    dy      = (y_r >= py_r) ? (y_r - py_r) : (py_r - y_r);
    tri_uv  = {2'b0, p[31:0]} + {1'b0, p[31:0], 1'b0};
    mul_a   = '0;
    mul_b   = '0;
    case (step_r) inside
      STEP_UU:  begin mul_a = {8'b0, u16};          mul_b = u16; end
      STEP_VV:  begin mul_a = {8'b0, v16};          mul_b = v16; end
      STEP_UV:  begin mul_a = {8'b0, u16};          mul_b = v16; end
      STEP_W0H: begin mul_a = {8'b0, v2_r[31:16]};  mul_b = v16; end
      STEP_W0L: begin mul_a = {8'b0, v2_r[15:0]};   mul_b = v16; end
      STEP_W3H: begin mul_a = {8'b0, u2_r[31:16]};  mul_b = u16; end
      STEP_W3L: begin mul_a = {8'b0, u2_r[15:0]};   mul_b = u16; end
      STEP_W1H: begin mul_a = {8'b0, uv3_r[31:16]}; mul_b = v16; end
      STEP_W1L: begin mul_a = {8'b0, uv3_r[15:0]};  mul_b = v16; end
      STEP_W2H: begin mul_a = {8'b0, uv3_r[31:16]}; mul_b = u16; end
      STEP_W2L: begin mul_a = {8'b0, uv3_r[15:0]};  mul_b = u16; end
      [STEP_X0:STEP_Y_END]: begin
        mul_a = whi ? wsel[47:24] : wsel[23:0];
        mul_b = qsel;
      end
      STEP_SQX: begin mul_a = {8'b0, dx}; mul_b = dx; end
      STEP_SQY: begin mul_a = {8'b0, dy}; mul_b = dy; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    mul_en = (state_r == ST_MUL) && !ph_r;

    // Restoring divide of 2^16 by the interval count (samples minus one), one quotient bit a cycle.
    drem_sh = {drem_r[5:0], (dcnt_r == 5'd0)};
    div_ge  = drem_sh >= {1'b0, d_r};
    drem_nx = div_ge ? (drem_sh - {1'b0, d_r}) : drem_sh;

    s_try = sres_r + {1'b0, sbit_r};
    s_ge  = srem_r >= s_try;

    rsum   = {1'b0, rem_r} + {1'b0, drem_r[5:0]};
    rcarry = rsum >= {1'b0, d_r};

    len_sum = {1'b0, total_r} + {7'b0, sres_r[16:0]};

    if (req.num_points < CNT_W'(2)) begin
      n_cl = CNT_W'(2);
    end else if (req.num_points > CNT_W'(MAX_POINTS)) begin
      n_cl = CNT_W'(MAX_POINTS);
    end else begin
      n_cl = req.num_points;
    end

    last      = (i_r == d_r);
    emit_fire = (state_r == ST_EMIT) && emit_ready;
  end

  assign busy       = (state_r != ST_IDLE);
  assign emit_valid = (state_r == ST_EMIT);

  always_comb begin
    emit_res.point_x      = x_r ^ CSIGN;
    emit_res.point_y      = y_r ^ CSIGN;
    emit_res.point_index  = i_r;
    emit_res.last_point   = last;
    emit_res.curve_length = last ? total_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ph_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt_r == 5'd16) begin
            state_r <= ST_PT;
          end
        end
        ST_PT: begin
          ph_r <= 1'b0;
          if (i_r == '0) begin
            state_r <= ST_EMIT;
          end else if (last) begin
            step_r  <= STEP_SQX;
            state_r <= ST_MUL;
          end else begin
            step_r  <= STEP_UU;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (step_r == STEP_Y_END) begin
              state_r <= ST_FIN;
            end else if (step_r == STEP_SQY) begin
              state_r <= ST_SQRT;
            end else begin
              step_r <= step_r + 5'd1;
            end
          end
        end
        ST_FIN: begin
          step_r  <= STEP_SQX;
          state_r <= ST_MUL;
        end
        ST_SQRT: begin
          if (sbit_r[0]) begin
            state_r <= ST_ADDL;
          end
        end
        ST_ADDL: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ready) begin
            state_r <= last ? ST_IDLE : ST_PT;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; only the sequencer state above needs a reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      qx_r[0] <= req.p0_x ^ CSIGN;
      qy_r[0] <= req.p0_y ^ CSIGN;
      qx_r[1] <= req.p1_x ^ CSIGN;
      qy_r[1] <= req.p1_y ^ CSIGN;
      qx_r[2] <= req.p2_x ^ CSIGN;
      qy_r[2] <= req.p2_y ^ CSIGN;
      qx_r[3] <= req.p3_x ^ CSIGN;
      qy_r[3] <= req.p3_y ^ CSIGN;
      d_r     <= IDX_W'(n_cl - CNT_W'(1));
      drem_r  <= '0;
      dcnt_r  <= '0;
      quo_r   <= '0;
    end

    if (state_r == ST_DIV) begin
      drem_r <= drem_nx;
      quo_r  <= {quo_r[U_W-2:0], div_ge};
      dcnt_r <= dcnt_r + 5'd1;
      if (dcnt_r == 5'd16) begin
        i_r     <= '0;
        u_r     <= '0;
        rem_r   <= '0;
        total_r <= '0;
      end
    end

    if (state_r == ST_PT) begin
      if (i_r == '0) begin
        x_r <= qx_r[0];
        y_r <= qy_r[0];
      end else if (last) begin
        x_r <= qx_r[3];
        y_r <= qy_r[3];
      end
    end

    if (state_r == ST_MUL && ph_r) begin
      case (step_r) inside
        STEP_UU:  u2_r  <= p[31:0];
        STEP_VV:  v2_r  <= p[31:0];
        STEP_UV:  uv3_r <= tri_uv[31:0];
        STEP_W0H: w_r[0] <= {p[31:0], 16'b0};
        STEP_W0L: w_r[0] <= w_r[0] + {16'b0, p[31:0]};
        STEP_W3H: w_r[3] <= {p[31:0], 16'b0};
        STEP_W3L: w_r[3] <= w_r[3] + {16'b0, p[31:0]};
        STEP_W1H: w_r[1] <= {p[31:0], 16'b0};
        STEP_W1L: w_r[1] <= w_r[1] + {16'b0, p[31:0]};
        STEP_W2H: w_r[2] <= {p[31:0], 16'b0};
        STEP_W2L: w_r[2] <= w_r[2] + {16'b0, p[31:0]};
        [STEP_X0:STEP_Y_END]: begin
          acc_r <= acc_sum;
          if (step_r == STEP_Y0) begin
            x_r <= acc_r[63:48];
          end
        end
        STEP_SQX: sq_r <= {2'b0, p[31:0]};
        STEP_SQY: begin
          srem_r <= {1'b0, sq_r + {2'b0, p[31:0]}};
          sres_r <= '0;
          sbit_r <= SBIT_TOP;
        end
        default: ;
      endcase
    end

    if (state_r == ST_FIN) begin
      y_r <= acc_r[63:48];
    end

    // Digit-by-digit square root, two radicand bits a cycle.
    if (state_r == ST_SQRT) begin
      if (s_ge) begin
        srem_r <= srem_r - s_try;
        sres_r <= (sres_r >> 1) + {1'b0, sbit_r};
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end

    if (state_r == ST_ADDL) begin
      total_r <= (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LEN_W-1:0];
    end

    if (emit_fire) begin
      px_r <= x_r;
      py_r <= y_r;
      if (!last) begin
        i_r   <= i_r + IDX_W'(1);
        rem_r <= rcarry ? IDX_W'(rsum - {1'b0, d_r}) : rsum[IDX_W-1:0];
        u_r   <= u_r + quo_r + {16'b0, rcarry};
      end
    end
  end

  `CBZ_ASSERT_NOW(a_rem_below_spacing, (state_r == ST_PT) || (state_r == ST_EMIT),
    rem_r < d_r, "parameter remainder reached the sample spacing")
  `CBZ_ASSERT_NOW(a_index_in_range, state_r == ST_EMIT, i_r <= d_r,
    "sample index ran past the last sample")
  `CBZ_ASSERT_NOW(a_interior_param, (state_r == ST_MUL) && (step_r < STEP_SQX),
    (u_r != '0) && !u_r[16], "interior sample has an endpoint parameter")
  `CBZ_ASSERT_NEXT(a_start_divides, (state_r == ST_IDLE) && start, state_r == ST_DIV,
    "accepted request did not enter the divide")
  `CBZ_ASSERT_NEXT(a_last_returns_idle, emit_fire && last, state_r == ST_IDLE,
    "sequencer did not return to idle after the last word")

endmodule

FILE: hdl/cubic_bezier_sampler.sv
// Timing: after a request is accepted the core runs the divide, then one setup and one emit
// state present the first word. Each interior sample then takes 29 multiplies, the square root
// and four control states; the last sample needs only the distance multiplies and the root.
// The input stays stalled until the core hands the last word of a request to the output register,
// so a new request is only accepted once the previous one is done (single multiplier).
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops the output word.
`timescale 1ns / 1ps

module cubic_bezier_sampler import cbz_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_p0_x,
  input  logic [COORD_WIDTH-1:0] in_p0_y,
  input  logic [COORD_WIDTH-1:0] in_p1_x,
  input  logic [COORD_WIDTH-1:0] in_p1_y,
  input  logic [COORD_WIDTH-1:0] in_p2_x,
  input  logic [COORD_WIDTH-1:0] in_p2_y,
  input  logic [COORD_WIDTH-1:0] in_p3_x,
  input  logic [COORD_WIDTH-1:0] in_p3_y,
  input  logic [CNT_W-1:0]       in_num_points,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] out_point_x,
  output logic [COORD_WIDTH-1:0] out_point_y,
  output logic [IDX_W-1:0]       out_point_index,
  output logic                   out_last_point,
  output logic [LEN_W-1:0]       out_curve_length
);

  // The core holds the whole request while it walks the samples, so the
  // input side is stalled for as long as the sequencer is busy.
  cbz_req_t req;
  cbz_res_t core_res;
  cbz_res_t res_r;
  logic     out_valid_r;
  logic     busy;
  logic     start;
  logic     emit_valid;
  logic     emit_ready;

  always_comb begin
    req.p0_x       = in_p0_x;
    req.p0_y       = in_p0_y;
    req.p1_x       = in_p1_x;
    req.p1_y       = in_p1_y;
    req.p2_x       = in_p2_x;
    req.p2_y       = in_p2_y;
    req.p3_x       = in_p3_x;
    req.p3_y       = in_p3_y;
    req.num_points = in_num_points;
  end

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // The output register takes a new word whenever it is empty or its
  // current word is being taken, so the core can compute the next sample
  // while a finished word still waits downstream.
  assign emit_ready = !out_valid_r || !out_stall;

  cbz_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The word itself needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = res_r.point_x;
  assign out_point_y      = res_r.point_y;
  assign out_point_index  = res_r.point_index;
  assign out_last_point   = res_r.last_point;
  assign out_curve_length = res_r.curve_length;

endmodule
